FILE: src/fked_pkg.sv
// package: types, constants and key tables of the function-key escape decoder
`timescale 1ns / 1ps
`default_nettype none

package fked_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CODE_W  = 9;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned HOLD_N  = 4;
  // console request, four held bytes and one more byte
  localparam int unsigned RES_MAX = 6;

  localparam logic [MODE_W-1:0] DIALECT_NONE    = 2'd0;
  localparam logic [MODE_W-1:0] DIALECT_TILDE   = 2'd1;
  localparam logic [MODE_W-1:0] DIALECT_BRACKET = 2'd2;

  localparam logic KIND_KEY     = 1'b0;
  localparam logic KIND_CONSOLE = 1'b1;

  localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h1b;
  localparam logic [BYTE_W-1:0] TILDE_BYTE = 8'h7e;
  localparam logic [BYTE_W-1:0] CR_BYTE    = 8'h0d;
  localparam logic [BYTE_W-1:0] LF_BYTE    = 8'h0a;
  localparam logic [CODE_W-1:0] KEY_BASE   = 9'h100;

  localparam logic [15:0] PFX_SS3  = 16'h4f1b;
  localparam logic [15:0] PFX_CSI  = 16'h5b1b;
  localparam logic [23:0] PFX_CSI1 = 24'h315b1b;
  localparam logic [23:0] PFX_CSI2 = 24'h325b1b;
  localparam logic [23:0] PFX_CSIO = 24'h4f5b1b;

  localparam logic [31:0] TILDE_SHORT [4] = '{
    32'h00504f1b, 32'h00514f1b, 32'h00524f1b, 32'h00534f1b
  };
  localparam logic [31:0] TILDE_LONG [8] = '{
    32'h35315b1b, 32'h37315b1b, 32'h38315b1b, 32'h39315b1b,
    32'h30325b1b, 32'h31325b1b, 32'h33325b1b, 32'h34325b1b
  };
  localparam logic [31:0] BRACKET_KEYS [12] = '{
    32'h504f5b1b, 32'h514f5b1b, 32'h524f5b1b, 32'h534f5b1b,
    32'h35315b1b, 32'h37315b1b, 32'h38315b1b, 32'h39315b1b,
    32'h38325b1b, 32'h39325b1b, 32'h33325b1b, 32'h34325b1b
  };

  typedef struct packed {
    logic              hit;
    logic [3:0]        idx;
  } match_t;

  typedef struct packed {
    logic              kind;
    logic [CODE_W-1:0] key_code;
  } res_t;

  function automatic match_t match_short(input logic [31:0] v);
    match_t m;
    m = '0;
    for (int i = 3; i >= 0; i--) begin
      if (TILDE_SHORT[i] == v) begin
        m.hit = 1'b1;
        m.idx = 4'(i);
      end
    end
    return m;
  endfunction

  function automatic match_t match_long(input logic [31:0] v);
    match_t m;
    m = '0;
    for (int i = 7; i >= 0; i--) begin
      if (TILDE_LONG[i] == v) begin
        m.hit = 1'b1;
        m.idx = 4'(i);
      end
    end
    return m;
  endfunction

  function automatic match_t match_bracket(input logic [31:0] v);
    match_t m;
    m = '0;
    for (int i = 11; i >= 0; i--) begin
      if (BRACKET_KEYS[i] == v) begin
        m.hit = 1'b1;
        m.idx = 4'(i);
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: src/fked_rx_if.sv
// interface: received byte channel
`timescale 1ns / 1ps
`default_nettype none

interface fked_rx_if;
  logic                          valid;
  logic                          ready;
  logic [fked_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: src/fked_key_if.sv
// interface: decoded key result channel
`timescale 1ns / 1ps
`default_nettype none

interface fked_key_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [fked_pkg::CODE_W-1:0]   key_code;
  logic                          last;

  modport source (output valid, output kind, output key_code, output last, input ready);
  modport sink (input valid, input kind, input key_code, input last, output ready);
endinterface

`default_nettype wire

FILE: src/fked_cfg_if.sv
// interface: dialect mode register write channel
`timescale 1ns / 1ps
`default_nettype none

interface fked_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fked_pkg::MODE_W-1:0]   dialect_mode;

  modport source (output valid, output dialect_mode, input ready);
  modport sink (input valid, input dialect_mode, output ready);
endinterface

`default_nettype wire

FILE: src/function_key_escape_decoder.sv
// top level: escape-sequence function-key decoder with result buffer
// first result of a byte is offered in the cycle after the byte is taken
// throughput: one result beat per cycle while key_o is ready; the next byte is
//   taken in the cycle its last beat goes
// bytes that give no result are taken every cycle
// reset clears the dialect mode, held bytes, escape run and result count, not the result buffer entries
`timescale 1ns / 1ps
`default_nettype none

module function_key_escape_decoder (
  input  wire              clk_i,
  input  wire              rst_ni,
  fked_rx_if.sink          rx_i,
  fked_key_if.source       key_o,
  fked_cfg_if.sink         cfg_i
);
  import fked_pkg::*;

  logic [MODE_W-1:0] mode_q;
  logic [31:0]       pend_q, pend_d;
  logic [2:0]        pcnt_q, pcnt_d;
  logic [2:0]        run_q, run_d;
  logic [2:0]        rem_q, n_d;
  res_t              res_q [RES_MAX];
  res_t              res_d [RES_MAX];

  logic              acc_rx, pop;
  logic [BYTE_W-1:0] in_byte;
  logic              req;
  logic [31:0]       app_b, fbuf;
  logic [2:0]        app_c, fcnt;
  logic              xtra_vld;
  logic [CODE_W-1:0] xtra;
  match_t            m_old_long, m_short, m_long, m_brk;

  assign acc_rx      = rx_i.valid & rx_i.ready;
  assign pop         = key_o.valid & key_o.ready;
  assign rx_i.ready  = (rem_q == 3'd0) || ((rem_q == 3'd1) && key_o.ready);
  assign cfg_i.ready = 1'b1;

  assign key_o.valid    = (rem_q != 3'd0);
  assign key_o.kind     = res_q[0].kind;
  assign key_o.key_code = res_q[0].key_code;
  assign key_o.last     = (rem_q == 3'd1);

  // escape run counter and console request
  always_comb begin
    req   = 1'b0;
    run_d = run_q;
    if (rx_i.rx_byte == ESC_BYTE) begin
      if (run_q < 3'd4) begin
        run_d = run_q + 3'd1;
        req   = (run_q == 3'd2);
      end
    end else begin
      run_d = '0;
    end
  end

  // byte after dialect mapping, and the held buffer with it appended
  always_comb begin
    in_byte = rx_i.rx_byte;
    if ((mode_q == DIALECT_BRACKET) && (rx_i.rx_byte == CR_BYTE)) begin
      in_byte = LF_BYTE;
    end
    app_b      = pend_q | ({24'b0, in_byte} << {pcnt_q[1:0], 3'b000});
    app_c      = pcnt_q + 3'd1;
    m_old_long = match_long(pend_q);
    m_short    = match_short(app_b);
    m_long     = match_long(app_b);
    m_brk      = match_bracket(app_b);
  end

  // sequence matcher: decides what to flush, what to hold, which key to emit
  always_comb begin
    pend_d   = pend_q;
    pcnt_d   = pcnt_q;
    fbuf     = pend_q;
    fcnt     = '0;
    xtra_vld = 1'b0;
    xtra     = {1'b0, in_byte};
    unique case (mode_q)
      DIALECT_TILDE: begin
        if (in_byte == TILDE_BYTE) begin
          pend_d = '0;
          pcnt_d = '0;
          if ((pcnt_q == 3'd4) && m_old_long.hit) begin
            xtra_vld = 1'b1;
            xtra     = KEY_BASE + 9'd5 + {5'b0, m_old_long.idx};
          end else begin
            fcnt     = pcnt_q;
            xtra_vld = 1'b1;
          end
        end else if (pcnt_q >= 3'd4) begin
          pend_d   = '0;
          pcnt_d   = '0;
          fcnt     = pcnt_q;
          xtra_vld = 1'b1;
        end else begin
          pend_d = app_b;
          pcnt_d = app_c;
          fbuf   = app_b;
          priority if (app_b[7:0] != ESC_BYTE) begin
            fcnt = app_c;
          end else if (app_c <= 3'd1) begin
          end else if ((app_b[15:0] != PFX_SS3) && (app_b[15:0] != PFX_CSI)) begin
            fcnt = app_c;
          end else if (app_c <= 3'd2) begin
          end else if (m_short.hit) begin
            xtra_vld = 1'b1;
            xtra     = KEY_BASE + 9'd1 + {5'b0, m_short.idx};
            pend_d   = '0;
            pcnt_d   = '0;
          end else if ((app_b[23:0] != PFX_CSI1) && (app_b[23:0] != PFX_CSI2)) begin
            fcnt = app_c;
          end else if (app_c <= 3'd3) begin
          end else if (m_long.hit) begin
          end else begin
            fcnt = app_c;
          end
          if (fcnt != 3'd0) begin
            pend_d = '0;
            pcnt_d = '0;
          end
        end
      end
      DIALECT_BRACKET: begin
        if (pcnt_q >= 3'd4) begin
          pend_d   = '0;
          pcnt_d   = '0;
          fcnt     = pcnt_q;
          xtra_vld = 1'b1;
        end else begin
          pend_d = app_b;
          pcnt_d = app_c;
          fbuf   = app_b;
          priority if (app_b[7:0] != ESC_BYTE) begin
            fcnt = app_c;
          end else if (app_c <= 3'd1) begin
          end else if (app_b[15:0] != PFX_CSI) begin
            fcnt = app_c;
          end else if (app_c <= 3'd2) begin
          end else if ((app_b[23:0] != PFX_CSIO) && (app_b[23:0] != PFX_CSI1) &&
                       (app_b[23:0] != PFX_CSI2)) begin
            fcnt = app_c;
          end else if (app_c <= 3'd3) begin
          end else if (m_brk.hit) begin
            xtra_vld = 1'b1;
            xtra     = KEY_BASE + 9'd1 + {5'b0, m_brk.idx};
            pend_d   = '0;
            pcnt_d   = '0;
          end else begin
            fcnt = app_c;
          end
          if (fcnt != 3'd0) begin
            pend_d = '0;
            pcnt_d = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result list: console request, flushed bytes, then the extra byte or key
  always_comb begin
    logic [2:0] j;
    j   = '0;
    n_d = {2'b0, req} + fcnt + {2'b0, xtra_vld};
    for (int s = 0; s < RES_MAX; s++) begin
      res_d[s] = '{kind: KIND_KEY, key_code: '0};
      if (req && (s == 0)) begin
        res_d[s].kind = KIND_CONSOLE;
      end else begin
        j = 3'(s) - {2'b0, req};
        for (int i = 0; i < HOLD_N; i++) begin
          if ((j == 3'(i)) && (3'(i) < fcnt)) begin
            res_d[s].key_code = {1'b0, fbuf[8*i +: 8]};
          end
        end
        if ((j == fcnt) && xtra_vld) begin
          res_d[s].key_code = xtra;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= DIALECT_NONE;
      pend_q <= '0;
      pcnt_q <= '0;
      run_q  <= '0;
      rem_q  <= '0;
    end else begin
      if (cfg_i.valid) begin
        mode_q <= cfg_i.dialect_mode;
      end
      if (acc_rx) begin
        pend_q <= pend_d;
        pcnt_q <= pcnt_d;
        run_q  <= run_d;
        rem_q  <= n_d;
      end else if (pop) begin
        rem_q <= rem_q - 3'd1;
      end
    end
  end

  // result buffer shifts down one entry per beat
  always_ff @(posedge clk_i) begin
    if (acc_rx) begin
      res_q <= res_d;
    end else if (pop) begin
      for (int i = 0; i < RES_MAX - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
    end
  end

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= 3'(RES_MAX))
    else $error("result count out of range");

  a_hold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcnt_q <= 3'(HOLD_N))
    else $error("held byte count out of range");

  a_run_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q <= 3'd4)
    else $error("escape run past saturation");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_rx |-> (rem_q == 3'd0) || (pop && (rem_q == 3'd1)))
    else $error("byte taken while results still pending");

  a_console_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_o.valid && (key_o.kind == KIND_CONSOLE)) |-> (key_o.key_code == '0))
    else $error("console request with nonzero code");

endmodule

`default_nettype wire

FILE: dv/tb.sv
// testbench: function-key escape decoder, directed byte table then random terminal streams
`timescale 1ns / 1ps

module tb;
  import fked_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RAND_ITEMS    = 320;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_WAIT      = 2000;
  localparam int IDLE_PCT      = 34;
  localparam int ESC_RUN_MAX   = 4;
  localparam int CONSOLE_RUN   = 3;

  localparam logic [BYTE_W-1:0] CSI_OPEN = 8'h5b;
  localparam logic [BYTE_W-1:0] SS3_OPEN = 8'h4f;
  localparam logic [BYTE_W-1:0] F1_FINAL = 8'h50;

  typedef enum logic {ROW_BYTE, ROW_MODE} row_op_e;

  // how a directed row is checked
  localparam logic [1:0] TYPED_NONE = 2'd0;
  localparam logic [1:0] TYPED_ONE  = 2'd1;
  localparam logic [1:0] FROM_MODEL = 2'd2;

  typedef struct packed {
    row_op_e           op;
    logic [BYTE_W-1:0] val;
    logic [1:0]        chk;
    logic              kind;
    logic [CODE_W-1:0] code;
  } dir_row_t;

  typedef struct packed {
    logic              kind;
    logic [CODE_W-1:0] code;
    logic              last;
  } key_beat_t;

  // digit pairs of F5..F12, first digit in the high byte
  localparam logic [15:0] TILDE_DIGITS [8] = '{"15", "17", "18", "19", "20", "21", "23", "24"};
  localparam logic [15:0] BRACKET_DIGITS [8] = '{"15", "17", "18", "19", "28", "29", "23", "24"};

  localparam int N_DIR = 27;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{ROW_BYTE, 8'h41, TYPED_NONE, KIND_KEY, 9'h000},
    '{ROW_BYTE, ESC_BYTE, TYPED_NONE, KIND_KEY, 9'h000},
    '{ROW_BYTE, ESC_BYTE, TYPED_NONE, KIND_KEY, 9'h000},
    '{ROW_BYTE, ESC_BYTE, TYPED_ONE, KIND_CONSOLE, 9'h000},
    '{ROW_BYTE, ESC_BYTE, TYPED_NONE, KIND_KEY, 9'h000},
    '{ROW_MODE, 8'(DIALECT_TILDE), TYPED_NONE, KIND_KEY, 9'h000},
    '{ROW_BYTE, 8'h00, TYPED_ONE, KIND_KEY, 9'h000},
    '{ROW_BYTE, 8'hff, TYPED_ONE, KIND_KEY, 9'h0ff},
    '{ROW_BYTE, ESC_BYTE, FROM_MODEL, KIND_KEY, 9'h000},
    '{ROW_BYTE, CSI_OPEN, FROM_MODEL, KIND_KEY, 9'h000},
    '{ROW_BYTE, 8'h32, FROM_MODEL, KIND_KEY, 9'h000},
    '{ROW_BYTE, 8'h34, FROM_MODEL, KIND_KEY, 9'h000},
    '{ROW_BYTE, TILDE_BYTE, TYPED_ONE, KIND_KEY, 9'h10c},
    '{ROW_BYTE, TILDE_BYTE, TYPED_ONE, KIND_KEY, 9'h07e},
    '{ROW_BYTE, ESC_BYTE, FROM_MODEL, KIND_KEY, 9'h000},
    '{ROW_BYTE, CSI_OPEN, FROM_MODEL, KIND_KEY, 9'h000},
    '{ROW_BYTE, 8'h31, FROM_MODEL, KIND_KEY, 9'h000},
    '{ROW_BYTE, 8'h35, FROM_MODEL, KIND_KEY, 9'h000},
    '{ROW_BYTE, 8'h41, FROM_MODEL, KIND_KEY, 9'h000},
    '{ROW_BYTE, ESC_BYTE, FROM_MODEL, KIND_KEY, 9'h000},
    '{ROW_BYTE, CSI_OPEN, FROM_MODEL, KIND_KEY, 9'h000},
    '{ROW_MODE, 8'(DIALECT_NONE), TYPED_NONE, KIND_KEY, 9'h000},
    '{ROW_BYTE, 8'h42, TYPED_NONE, KIND_KEY, 9'h000},
    '{ROW_MODE, 8'(DIALECT_BRACKET), TYPED_NONE, KIND_KEY, 9'h000},
    '{ROW_BYTE, SS3_OPEN, FROM_MODEL, KIND_KEY, 9'h000},
    '{ROW_BYTE, 8'h51, TYPED_ONE, KIND_KEY, 9'h102},
    '{ROW_BYTE, CR_BYTE, TYPED_ONE, KIND_KEY, 9'h00a}
  };

  logic clk = 1'b0;
  logic rst_n;

  fked_rx_if  rx_ch ();
  fked_key_if key_ch ();
  fked_cfg_if cfg_ch ();

  function_key_escape_decoder u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_ch),
    .key_o  (key_ch),
    .cfg_i  (cfg_ch)
  );

  always #5 clk = ~clk;

  // decoder state as seen from outside
  logic [MODE_W-1:0] mode_q = DIALECT_NONE;
  logic [31:0]       held = '0;
  int unsigned       held_n = 0;
  int unsigned       esc_run = 0;
  key_beat_t         byte_res [$];
  key_beat_t         key_q [$];

  int fails = 0;
  int counted = 0;
  int idle_pct = IDLE_PCT;
  int cycles = 0;

  function automatic void emit(input logic k, input logic [CODE_W-1:0] c);
    byte_res.push_back('{kind: k, code: c, last: 1'b0});
  endfunction

  function automatic void flush_held();
    for (int i = 0; i < held_n; i++) emit(KIND_KEY, CODE_W'(held[8*i +: 8]));
    held = '0;
    held_n = 0;
  endfunction

  // true when the byte went out behind four held ones
  function automatic bit hold_byte(input logic [BYTE_W-1:0] b);
    if (held_n >= HOLD_N) begin
      flush_held();
      emit(KIND_KEY, CODE_W'(b));
      return 1'b1;
    end
    held[8*held_n +: 8] = b;
    held_n++;
    return 1'b0;
  endfunction

  // key number of a four-byte sequence, 0 when it is none
  function automatic int csi_key(input logic [31:0] v, input bit bracket);
    logic [15:0] d;
    for (int i = 0; i < 8; i++) begin
      d = bracket ? BRACKET_DIGITS[i] : TILDE_DIGITS[i];
      if (v == {d[7:0], d[15:8], CSI_OPEN, ESC_BYTE}) return 5 + i;
    end
    for (int i = 0; i < 4; i++) begin
      if (bracket && v == {8'(F1_FINAL + i), SS3_OPEN, CSI_OPEN, ESC_BYTE}) return 1 + i;
    end
    return 0;
  endfunction

  function automatic void tilde_step(input logic [BYTE_W-1:0] b);
    int k;
    if (b == TILDE_BYTE) begin
      k = (held_n == HOLD_N) ? csi_key(held, 1'b0) : 0;
      if (k != 0) begin
        held = '0;
        held_n = 0;
        emit(KIND_KEY, KEY_BASE + CODE_W'(k));
      end else begin
        flush_held();
        emit(KIND_KEY, CODE_W'(b));
      end
      return;
    end
    if (hold_byte(b)) return;
    if (held[7:0] != ESC_BYTE) begin
      flush_held();
    end else if (held_n >= 2 && held[15:0] != PFX_SS3 && held[15:0] != PFX_CSI) begin
      flush_held();
    end else if (held_n == 3 && held[15:0] == PFX_SS3 &&
                 held[23:16] >= F1_FINAL && held[23:16] <= F1_FINAL + 8'd3) begin
      emit(KIND_KEY, KEY_BASE + 9'd1 + CODE_W'(held[23:16] - F1_FINAL));
      held = '0;
      held_n = 0;
    end else if (held_n >= 3 && held[23:0] != PFX_CSI1 && held[23:0] != PFX_CSI2) begin
      flush_held();
    end else if (held_n == HOLD_N && csi_key(held, 1'b0) == 0) begin
      flush_held();
    end
  endfunction

  function automatic void bracket_step(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    int k;
    c = (b == CR_BYTE) ? LF_BYTE : b;
    if (hold_byte(c)) return;
    if (held[7:0] != ESC_BYTE) begin
      flush_held();
    end else if (held_n >= 2 && held[15:0] != PFX_CSI) begin
      flush_held();
    end else if (held_n >= 3 && held[23:0] != PFX_CSIO && held[23:0] != PFX_CSI1 &&
                 held[23:0] != PFX_CSI2) begin
      flush_held();
    end else if (held_n == HOLD_N) begin
      k = csi_key(held, 1'b1);
      if (k != 0) begin
        held = '0;
        held_n = 0;
        emit(KIND_KEY, KEY_BASE + CODE_W'(k));
      end else begin
        flush_held();
      end
    end
  endfunction

  function automatic void predict_byte(input logic [BYTE_W-1:0] b);
    byte_res.delete();
    if (b == ESC_BYTE) begin
      if (esc_run < ESC_RUN_MAX) begin
        esc_run++;
        if (esc_run == CONSOLE_RUN) emit(KIND_CONSOLE, '0);
      end
    end else begin
      esc_run = 0;
    end
    if (mode_q == DIALECT_TILDE) tilde_step(b);
    else if (mode_q == DIALECT_BRACKET) bracket_step(b);
    if (byte_res.size() != 0) byte_res[byte_res.size()-1].last = 1'b1;
  endfunction

  // sequence bytes weighted up among random bytes
  function automatic logic [BYTE_W-1:0] noise_byte();
    case ($urandom_range(9))
      0: return ESC_BYTE;
      1: return TILDE_BYTE;
      2: return CR_BYTE;
      3: return CSI_OPEN;
      default: return BYTE_W'($urandom_range(255));
    endcase
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [1:0] chk,
                           input logic exp_kind, input logic [CODE_W-1:0] exp_code);
    while ($urandom_range(99) < idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (rx_ch.ready !== 1'b1);
    predict_byte(b);
    if (chk == FROM_MODEL) begin
      foreach (byte_res[i]) key_q.push_back(byte_res[i]);
    end else if (chk == TYPED_ONE) begin
      key_q.push_back('{kind: exp_kind, code: exp_code, last: 1'b1});
    end
    counted++;
  endtask

  // wait for every expected beat, then give a byte with no result time to retire
  task automatic settle();
    rx_ch.valid <= 1'b0;
    while (key_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] m);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.dialect_mode <= m;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    mode_q = m;
  endtask

  initial begin
    key_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      key_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin : check_beats
    key_beat_t want;
    if (rst_n === 1'b1 && key_ch.valid === 1'b1 && key_ch.ready === 1'b1) begin
      if (key_q.size() == 0) begin
        $error("key beat with nothing expected: kind %0d key_code %h last %0b",
               key_ch.kind, key_ch.key_code, key_ch.last);
        fails++;
      end else begin
        want = key_q.pop_front();
        if (key_ch.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, key_ch.kind);
          fails++;
        end
        if (key_ch.key_code !== want.code) begin
          $error("key_code: expected %h, got %h", want.code, key_ch.key_code);
          fails++;
        end
        if (key_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, key_ch.last);
          fails++;
        end
      end
    end
  end

  initial begin
    logic [BYTE_W-1:0] seq [$];
    logic [MODE_W-1:0] phase_mode;
    logic [15:0]       digits;
    int                phase;
    int                phase_len;
    int                in_phase;
    int                cut;
    int                key_n;
    int                pick;
    int                burst;
    int                leftover;
    bit                use_bracket;

    rst_n               <= 1'b0;
    rx_ch.valid         <= 1'b0;
    rx_ch.rx_byte       <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.dialect_mode <= DIALECT_NONE;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].op == ROW_MODE) begin
        settle();
        write_mode(DIR_ROWS[i].val[MODE_W-1:0]);
      end else begin
        send_byte(DIR_ROWS[i].val, DIR_ROWS[i].chk, DIR_ROWS[i].kind, DIR_ROWS[i].code);
      end
    end

    counted = 0;
    phase = 0;
    while (counted < RAND_ITEMS) begin
      settle();
      case (phase)
        0: phase_mode = DIALECT_BRACKET;
        1: phase_mode = DIALECT_TILDE;
        2: phase_mode = DIALECT_NONE;
        3: phase_mode = DIALECT_TILDE;
        4: phase_mode = DIALECT_BRACKET;
        default: phase_mode = MODE_W'($urandom_range(int'(DIALECT_BRACKET)));
      endcase
      // one phase runs with both sides always ready
      idle_pct = (phase == 3) ? 0 : IDLE_PCT;
      write_mode(phase_mode);
      phase_len = $urandom_range(30, 50);
      in_phase = 0;
      while (in_phase < phase_len) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          use_bracket = (phase_mode == DIALECT_BRACKET);
          if (phase_mode == DIALECT_NONE || $urandom_range(9) < 2)
            use_bracket = $urandom_range(1);
          key_n = $urandom_range(11);
          seq.delete();
          seq.push_back(ESC_BYTE);
          if (use_bracket) seq.push_back(CSI_OPEN);
          if (key_n < 4) begin
            seq.push_back(SS3_OPEN);
            seq.push_back(8'(F1_FINAL + key_n));
          end else begin
            digits = use_bracket ? BRACKET_DIGITS[key_n-4] : TILDE_DIGITS[key_n-4];
            if (!use_bracket) seq.push_back(CSI_OPEN);
            seq.push_back(digits[15:8]);
            seq.push_back(digits[7:0]);
            if (!use_bracket) seq.push_back(TILDE_BYTE);
          end
          // a quarter of the sequences break off and take a random byte
          cut = ($urandom_range(3) == 0) ? $urandom_range(1, seq.size() - 1) : seq.size();
          for (int i = 0; i < cut; i++) send_byte(seq[i], FROM_MODEL, KIND_KEY, '0);
          if (cut < seq.size()) send_byte(noise_byte(), FROM_MODEL, KIND_KEY, '0);
          in_phase += cut + 1;
        end else if (pick < 65) begin
          burst = $urandom_range(1, 5);
          repeat (burst) send_byte(ESC_BYTE, FROM_MODEL, KIND_KEY, '0);
          in_phase += burst;
        end else begin
          send_byte(noise_byte(), FROM_MODEL, KIND_KEY, '0);
          in_phase++;
        end
      end
      phase++;
    end

    rx_ch.valid <= 1'b0;
    for (int w = 0; w < END_WAIT && key_q.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    leftover = key_q.size();
    if (leftover != 0) $error("%0d expected key beats never arrived", leftover);
    if (fails == 0 && leftover == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
src/fked_pkg.sv
src/fked_rx_if.sv
src/fked_key_if.sv
src/fked_cfg_if.sv
src/function_key_escape_decoder.sv
dv/tb.sv
